// ----- hw/rtl/fixed_width_id_packer_64_core_defines.svh -----
// ----------------------------------------------------------------------------
// Fixed-width id packer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_WIDTH_ID_PACKER_64_CORE_DEFINES_SVH
`define FIXED_WIDTH_ID_PACKER_64_CORE_DEFINES_SVH

// Same-cycle implication.
`define FWIDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWIDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fwidp_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-width id packer package
// Widths, reset values, the queue entry type and the entry width clamp.
// ----------------------------------------------------------------------------
package fwidp_pkg;

  localparam int unsigned WordWidthDef  = 64;
  localparam int unsigned OutWidth      = 64;
  localparam int unsigned TypeWidth     = 16;
  localparam int unsigned MetaWidth     = 4;
  localparam int unsigned IdWidth       = 32;
  localparam int unsigned CfgWidth      = 6;
  localparam int unsigned AddrWidth     = 2;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned FifoDepthDef  = 4;

  localparam logic [CfgWidth-1:0] BitsPerEntryRst = CfgWidth'(13);
  localparam logic [CfgWidth-1:0] EntryWidthMin   = CfgWidth'(1);
  localparam logic [CfgWidth-1:0] EntryWidthMax   = CfgWidth'(32);

  typedef struct packed {
    logic [IdWidth-1:0]  id;
    logic [CfgWidth-1:0] width;
    logic                last;
  } entry_t;

  function automatic logic [CfgWidth-1:0] entry_width(input logic [CfgWidth-1:0] cfg);
    logic [CfgWidth-1:0] w;
    if (cfg == '0) begin
      w = EntryWidthMin;
    end else if (cfg > EntryWidthMax) begin
      w = EntryWidthMax;
    end else begin
      w = cfg;
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/fwidp_front.sv -----
// ----------------------------------------------------------------------------
// Fixed-width id packer: front end
// Accepts block beats, forms the masked id and registers it with its width.
// ----------------------------------------------------------------------------
module fwidp_front import fwidp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CfgWidth-1:0]  bits_per_entry_i,
  input  logic [TypeWidth-1:0] block_type_i,
  input  logic [MetaWidth-1:0] block_meta_i,
  input  logic                 last_block_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 ent_valid_o,
  output entry_t               ent_o,
  input  logic                 ent_ready_i
);

  logic [CfgWidth-1:0] width;
  logic [IdWidth-1:0]  mask;
  entry_t              ent_d, ent_q;
  logic                valid_d, valid_q;

  always_comb begin
    width       = entry_width(bits_per_entry_i);
    mask        = {IdWidth{1'b1}} >> (CfgWidth'(IdWidth) - width);
    ent_d.id    = IdWidth'({block_type_i, block_meta_i}) & mask;
    ent_d.width = width;
    ent_d.last  = last_block_i;
  end

  assign in_ready_o  = !valid_q || ent_ready_i;
  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (ent_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_q <= ent_d;
    end
  end

endmodule

// ----- hw/rtl/fwidp_fifo.sv -----
// ----------------------------------------------------------------------------
// Fixed-width id packer: entry queue
// Short first-in first-out queue that decouples the front end from the packer.
// ----------------------------------------------------------------------------
module fwidp_fifo import fwidp_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// ----- hw/rtl/fwidp_back.sv -----
// ----------------------------------------------------------------------------
// Fixed-width id packer: packing back end
// Shifts ids into the accumulator, emits full and flushed words through an
// output register.
// ----------------------------------------------------------------------------
`include "fixed_width_id_packer_64_core_defines.svh"

module fwidp_back import fwidp_pkg::*; #(
  parameter int unsigned WordWidth = WordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ent_valid_i,
  output logic                ent_ready_o,
  input  entry_t              ent_i,
  output logic [OutWidth-1:0] packed_word_o,
  output logic                last_word_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  localparam int unsigned OffW  = $clog2(WordWidth);
  localparam int unsigned SumW  = OffW + 1;
  localparam int unsigned WideW = WordWidth + IdWidth;

  logic [WordWidth-1:0] acc_d, acc_q;
  logic [OffW-1:0]      off_d, off_q;
  logic                 pend_d, pend_q;
  logic [WordWidth-1:0] word_d, word_q;
  logic                 last_d, last_q;
  logic                 ovld_d, ovld_q;

  logic [WideW-1:0]     wide;
  logic [WordWidth-1:0] merged;
  logic [IdWidth-1:0]   rem;
  logic [SumW-1:0]      sum;
  logic                 full;
  logic [OffW-1:0]      carry;
  logic                 slot_free;
  logic                 pop;
  logic                 load;

  always_comb begin
    wide   = WideW'(ent_i.id) << off_q;
    merged = acc_q | wide[WordWidth-1:0];
    rem    = wide[WideW-1:WordWidth];
    sum    = SumW'(off_q) + SumW'(ent_i.width);
    full   = sum >= SumW'(WordWidth);
    carry  = OffW'(sum - SumW'(WordWidth));
  end

  assign slot_free = !ovld_q || out_ready_i;

  always_comb begin
    acc_d  = acc_q;
    off_d  = off_q;
    pend_d = pend_q;
    word_d = word_q;
    last_d = last_q;
    ovld_d = ovld_q && !out_ready_i;
    pop    = 1'b0;
    load   = 1'b0;
    if (pend_q) begin
      if (slot_free) begin
        load   = 1'b1;
        word_d = acc_q;
        last_d = 1'b1;
        acc_d  = '0;
        off_d  = '0;
        pend_d = 1'b0;
      end
    end else if (ent_valid_i) begin
      if (!full && !ent_i.last) begin
        pop   = 1'b1;
        acc_d = merged;
        off_d = OffW'(sum);
      end else if (slot_free) begin
        pop    = 1'b1;
        load   = 1'b1;
        word_d = merged;
        if (!full) begin
          last_d = 1'b1;
          acc_d  = '0;
          off_d  = '0;
        end else if (ent_i.last && carry == '0) begin
          last_d = 1'b1;
          acc_d  = '0;
          off_d  = '0;
        end else begin
          last_d = 1'b0;
          acc_d  = WordWidth'(rem);
          off_d  = carry;
          pend_d = ent_i.last;
        end
      end
    end
    if (load) begin
      ovld_d = 1'b1;
    end
  end

  assign ent_ready_o   = pop;
  assign packed_word_o = OutWidth'(word_q);
  assign last_word_o   = last_q;
  assign out_valid_o   = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      off_q  <= '0;
      pend_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      off_q  <= off_d;
      pend_q <= pend_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  `FWIDP_ASSERT_IMP(a_pend_has_bits, pend_q, off_q != '0, "Pending flush with no bits")
  `FWIDP_ASSERT_IMP(a_pend_blocks_pop, pend_q, !pop, "Entry taken during flush")
  `FWIDP_ASSERT_NXT(a_last_clears, load && last_d, off_q == '0 && acc_q == '0, "Packer not cleared")

endmodule

// ----- hw/rtl/fixed_width_id_packer_64_core.sv -----
// ----------------------------------------------------------------------------
// Fixed-width id packer core
// Packs masked block ids least significant first into fixed-width words.
// ----------------------------------------------------------------------------
// Input beats carry a block type, a metadata nibble and a last flag on a
// valid/ready channel; output beats carry one packed word and a last flag.
// Each id is the type shifted left by four, ORed with the metadata and masked
// to bits_per_entry bits (written over the APB port, 0 reads as 1, values
// above 32 as 32). An id may straddle two words.
// A word leaves when it fills; a beat marked last flushes the partial word.
// The block takes one beat per cycle while nothing downstream stalls; a beat
// that completes a word passes the front register and the queue before it is
// loaded into the output register. A last beat that straddles a word
// boundary yields two words, the full one and then the remainder, and holds
// the packer from taking entries until the remainder is loaded.
// The front stage and a four-entry queue absorb a stalled receiver, so input
// beats keep being taken until both the queue and the front stage are full.
// Reset empties the queue and the accumulator and sets bits_per_entry to 13.
module fixed_width_id_packer_64_core import fwidp_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef,
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic [TypeWidth-1:0] block_type_i,
  input  logic [MetaWidth-1:0] block_meta_i,
  input  logic                 last_block_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic [OutWidth-1:0]  packed_word_o,
  output logic                 last_word_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  logic [CfgWidth-1:0] bpe_q;
  logic                cfg_wr;
  logic                f_valid, f_ready;
  entry_t              f_ent;
  logic                q_valid, q_ready;
  entry_t              q_ent;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrWidth-1:0] == '0 || 1'b1);
  assign prdata = DataWidth'(bpe_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpe_q <= BitsPerEntryRst;
    end else if (cfg_wr) begin
      bpe_q <= pwdata[CfgWidth-1:0];
    end
  end

  fwidp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bits_per_entry_i(bpe_q),
    .block_type_i    (block_type_i),
    .block_meta_i    (block_meta_i),
    .last_block_i    (last_block_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ent_valid_o     (f_valid),
    .ent_o           (f_ent),
    .ent_ready_i     (f_ready)
  );

  fwidp_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_i      (f_ent),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_o       (q_ent)
  );

  fwidp_back #(
    .WordWidth(WORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (q_valid),
    .ent_ready_o  (q_ready),
    .ent_i        (q_ent),
    .packed_word_o(packed_word_o),
    .last_word_o  (last_word_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
